[hdl/partition_child_block_expander_assert.svh]
// Assertion macros for the partition child block expander checker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef PARTITION_CHILD_BLOCK_EXPANDER_ASSERT_SVH
`define PARTITION_CHILD_BLOCK_EXPANDER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define PCBE_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define PCBE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pcbe_pkg.sv]
// Shared types, constants and size tables for the partition child block expander.
// No dependencies.
`timescale 1ns / 1ps

package pcbe_pkg;

	localparam int POS_W    = 14;
	localparam int SIZE_W   = 5;
	localparam int SYM_W    = 4;
	localparam int FRAME_W  = 15;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_CHILD = 4;
	localparam int CNT_W    = 3;
	localparam int IDX_W    = 2;
	localparam int MI_LIMIT_DEF = 16384;

	localparam logic [SIZE_W-1:0] SIZE_INVALID = 5'd22;
	localparam logic [SIZE_W-1:0] SIZE_8X8     = 5'd3;
	localparam logic [SIZE_W-1:0] BLOCK_LAST   = 5'd21;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'd1;

	typedef enum logic [3:0] {
		P_NONE   = 4'd0,
		P_HORZ   = 4'd1,
		P_VERT   = 4'd2,
		P_SPLIT  = 4'd3,
		P_HORZ_A = 4'd4,
		P_HORZ_B = 4'd5,
		P_VERT_A = 4'd6,
		P_VERT_B = 4'd7,
		P_HORZ_4 = 4'd8,
		P_VERT_4 = 4'd9
	} ptype_t;

	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [SIZE_W-1:0] size;
		logic              is_node;
	} child_t;

	typedef struct packed {
		child_t [MAX_CHILD-1:0] ch;
		logic [CNT_W-1:0]       cnt;
	} child_list_t;

	// Block width in 4x4 units.
	function automatic logic [5:0] block_wide(input logic [SIZE_W-1:0] b);
		logic [5:0] w;
		case (b)
			5'd0, 5'd1, 5'd16:          w = 6'd1;
			5'd2, 5'd3, 5'd4, 5'd18:    w = 6'd2;
			5'd5, 5'd6, 5'd7, 5'd17,
			5'd20:                      w = 6'd4;
			5'd8, 5'd9, 5'd10, 5'd19:   w = 6'd8;
			5'd11, 5'd12, 5'd13, 5'd21: w = 6'd16;
			5'd14, 5'd15:               w = 6'd32;
			default:                    w = 6'd0;
		endcase
		return w;
	endfunction

	// Child size for a partition type and a parent size.
	function automatic logic [SIZE_W-1:0] sub_size(input ptype_t p, input logic [SIZE_W-1:0] b);
		logic [SIZE_W-1:0] s;
		logic              sq;
		sq = (b == 5'd3) || (b == 5'd6) || (b == 5'd9) || (b == 5'd12) || (b == 5'd15);
		s = SIZE_INVALID;
		case (p)
			P_NONE: begin
				if (sq || b == 5'd0)
					s = b;
			end
			P_SPLIT: begin
				if (sq)
					s = b - 5'd3;
			end
			P_HORZ, P_HORZ_A, P_HORZ_B: begin
				if (sq)
					s = b - 5'd1;
			end
			P_VERT, P_VERT_A, P_VERT_B: begin
				if (sq)
					s = b - 5'd2;
			end
			P_HORZ_4: begin
				case (b)
					5'd6:    s = 5'd17;
					5'd9:    s = 5'd19;
					5'd12:   s = 5'd21;
					default: s = SIZE_INVALID;
				endcase
			end
			P_VERT_4: begin
				case (b)
					5'd6:    s = 5'd16;
					5'd9:    s = 5'd18;
					5'd12:   s = 5'd20;
					default: s = SIZE_INVALID;
				endcase
			end
			default: s = SIZE_INVALID;
		endcase
		return s;
	endfunction

endpackage

[hdl/pcbe_decode.sv]
// Partition type selection and child list construction for one node.
// Depends on pcbe_pkg.
`timescale 1ns / 1ps

module pcbe_decode
	import pcbe_pkg::*;
(
	input  logic [POS_W-1:0]   node_row,
	input  logic [POS_W-1:0]   node_col,
	input  logic [SIZE_W-1:0]  node_size,
	input  logic [SYM_W-1:0]   partition_symbol,
	input  logic [FRAME_W-1:0] rows,
	input  logic [FRAME_W-1:0] cols,
	output child_list_t        list
);

	logic [15:0]       r_e, c_e, rows_e, cols_e;
	logic [5:0]        wide;
	logic [4:0]        half;
	logic [3:0]        q;
	logic [15:0]       r_h, c_h, r_q, c_q, r_2q, c_2q, r_3q, c_3q;
	logic              in_frame, has_rows, has_cols;
	ptype_t            ptype;
	logic [SIZE_W-1:0] sub, spl;

	always_comb begin
		r_e    = {2'b00, node_row};
		c_e    = {2'b00, node_col};
		rows_e = {1'b0, rows};
		cols_e = {1'b0, cols};
		wide   = block_wide(node_size);
		half   = wide[5:1];
		q      = half[4:1];
		r_h    = r_e + {11'b0, half};
		c_h    = c_e + {11'b0, half};
		r_q    = r_e + {12'b0, q};
		c_q    = c_e + {12'b0, q};
		r_2q   = r_e + {11'b0, q, 1'b0};
		c_2q   = c_e + {11'b0, q, 1'b0};
		r_3q   = r_2q + {12'b0, q};
		c_3q   = c_2q + {12'b0, q};
		in_frame = (node_size <= BLOCK_LAST) && (r_e < rows_e) && (c_e < cols_e);
		has_rows = r_h < rows_e;
		has_cols = c_h < cols_e;

		if (node_size < SIZE_8X8)
			ptype = P_NONE;
		else if (has_rows && has_cols)
			ptype = (partition_symbol > 4'd9) ? P_VERT_4 : ptype_t'(partition_symbol);
		else if (has_cols)
			ptype = partition_symbol[0] ? P_SPLIT : P_HORZ;
		else if (has_rows)
			ptype = partition_symbol[0] ? P_SPLIT : P_VERT;
		else
			ptype = P_SPLIT;

		sub = sub_size(ptype, node_size);
		spl = sub_size(P_SPLIT, node_size);

		for (int i = 0; i < MAX_CHILD; i++) begin
			list.ch[i] = '{row: node_row, col: node_col, size: sub, is_node: 1'b0};
		end
		list.cnt = '0;

		case (ptype)
			P_NONE: begin
				list.cnt = 3'd1;
			end
			P_HORZ: begin
				list.ch[1].row = r_h[POS_W-1:0];
				list.cnt = has_rows ? 3'd2 : 3'd1;
			end
			P_VERT: begin
				list.ch[1].col = c_h[POS_W-1:0];
				list.cnt = has_cols ? 3'd2 : 3'd1;
			end
			P_SPLIT: begin
				for (int i = 0; i < MAX_CHILD; i++) begin
					list.ch[i].is_node = 1'b1;
				end
				list.ch[1].col = c_h[POS_W-1:0];
				list.ch[2].row = r_h[POS_W-1:0];
				list.ch[3].row = r_h[POS_W-1:0];
				list.ch[3].col = c_h[POS_W-1:0];
				list.cnt = 3'd4;
			end
			P_HORZ_A: begin
				list.ch[0].size = spl;
				list.ch[1].size = spl;
				list.ch[1].col  = c_h[POS_W-1:0];
				list.ch[2].row  = r_h[POS_W-1:0];
				list.cnt = 3'd3;
			end
			P_HORZ_B: begin
				list.ch[1].size = spl;
				list.ch[1].row  = r_h[POS_W-1:0];
				list.ch[2].size = spl;
				list.ch[2].row  = r_h[POS_W-1:0];
				list.ch[2].col  = c_h[POS_W-1:0];
				list.cnt = 3'd3;
			end
			P_VERT_A: begin
				list.ch[0].size = spl;
				list.ch[1].size = spl;
				list.ch[1].row  = r_h[POS_W-1:0];
				list.ch[2].col  = c_h[POS_W-1:0];
				list.cnt = 3'd3;
			end
			P_VERT_B: begin
				list.ch[1].size = spl;
				list.ch[1].col  = c_h[POS_W-1:0];
				list.ch[2].size = spl;
				list.ch[2].row  = r_h[POS_W-1:0];
				list.ch[2].col  = c_h[POS_W-1:0];
				list.cnt = 3'd3;
			end
			P_HORZ_4: begin
				list.ch[1].row = r_q[POS_W-1:0];
				list.ch[2].row = r_2q[POS_W-1:0];
				list.ch[3].row = r_3q[POS_W-1:0];
				list.cnt = (r_3q < rows_e) ? 3'd4 : 3'd3;
			end
			default: begin
				list.ch[1].col = c_q[POS_W-1:0];
				list.ch[2].col = c_2q[POS_W-1:0];
				list.ch[3].col = c_3q[POS_W-1:0];
				list.cnt = (c_3q < cols_e) ? 3'd4 : 3'd3;
			end
		endcase

		if (!in_frame)
			list.cnt = '0;
	end

endmodule

[hdl/pcbe_emit.sv]
// Child buffer that holds the list of one node and sends one child per cycle.
// Depends on pcbe_pkg.
`timescale 1ns / 1ps

module pcbe_emit
	import pcbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_req,
	input  child_list_t       list,
	output logic              take,
	output logic              child_strobe,
	output logic [POS_W-1:0]  child_row,
	output logic [POS_W-1:0]  child_col,
	output logic [SIZE_W-1:0] child_size,
	output logic              child_is_node,
	output logic              last_child
);

	child_t [MAX_CHILD-1:0] buf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   last;

	assign last = (cnt_q != '0) && ({1'b0, idx_q} == cnt_q - 3'd1);
	assign take = (cnt_q == '0) || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load_req && take) begin
			cnt_q <= list.cnt;
			idx_q <= '0;
		end else if (cnt_q != '0) begin
			if (last)
				cnt_q <= '0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req && take)
			buf_q <= list.ch;
	end

	assign child_strobe  = cnt_q != '0;
	assign child_row     = buf_q[idx_q].row;
	assign child_col     = buf_q[idx_q].col;
	assign child_size    = buf_q[idx_q].size;
	assign child_is_node = buf_q[idx_q].is_node;
	assign last_child    = last;

endmodule

[hdl/partition_child_block_expander.sv]
// Top level of the partition child block expander: frame registers, node register,
// decoder and child buffer. Depends on pcbe_pkg, pcbe_decode and pcbe_emit.
`timescale 1ns / 1ps

// A node is taken when start is high and busy is low, and its children appear on the
// child ports one per cycle, each beat marked by child_strobe. When the child buffer is
// free, the node passes from the node register into the child buffer, whose first child
// then goes on the ports; otherwise the first child follows the last beat of the node
// before it. The receiver cannot stall the block. The child buffer sends one beat per
// cycle and holds a node until its last child has left; a node with no children does
// not hold it. The node register takes the next node meanwhile, so the block can take
// a new node before the children of the one before it have all left.
module partition_child_block_expander
	import pcbe_pkg::*;
#(
	parameter int MI_LIMIT = MI_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [POS_W-1:0]     node_row,
	input  logic [POS_W-1:0]     node_col,
	input  logic [SIZE_W-1:0]    node_size,
	input  logic [SYM_W-1:0]     partition_symbol,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	output logic                 child_strobe,
	output logic [POS_W-1:0]     child_row,
	output logic [POS_W-1:0]     child_col,
	output logic [SIZE_W-1:0]    child_size,
	output logic                 child_is_node,
	output logic                 last_child
);

	logic [FRAME_W-1:0] frame_rows_q, frame_cols_q, rows, cols;
	logic               valid_s1;
	logic [POS_W-1:0]   row_s1, col_s1;
	logic [SIZE_W-1:0]  size_s1;
	logic [SYM_W-1:0]   sym_s1;
	logic               accept, take;
	child_list_t        list;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= '0;
			frame_cols_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				CFG_FRAME_COLS: frame_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows = ({17'b0, frame_rows_q} > 32'(MI_LIMIT)) ? FRAME_W'(MI_LIMIT) : frame_rows_q;
	assign cols = ({17'b0, frame_cols_q} > 32'(MI_LIMIT)) ? FRAME_W'(MI_LIMIT) : frame_cols_q;

	assign busy   = valid_s1 && !take;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1  <= node_row;
			col_s1  <= node_col;
			size_s1 <= node_size;
			sym_s1  <= partition_symbol;
		end
	end

	pcbe_decode u_decode (
		.node_row         (row_s1),
		.node_col         (col_s1),
		.node_size        (size_s1),
		.partition_symbol (sym_s1),
		.rows             (rows),
		.cols             (cols),
		.list             (list)
	);

	pcbe_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_req      (valid_s1),
		.list          (list),
		.take          (take),
		.child_strobe  (child_strobe),
		.child_row     (child_row),
		.child_col     (child_col),
		.child_size    (child_size),
		.child_is_node (child_is_node),
		.last_child    (last_child)
	);

endmodule

[hdl/pcbe_checker.sv]
// Port-level checks for the partition child block expander, bound to the top level.
// Depends on partition_child_block_expander_assert.svh.
`timescale 1ns / 1ps
`include "partition_child_block_expander_assert.svh"

module pcbe_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic child_strobe,
	input logic child_is_node,
	input logic last_child
);

	// The children of one node leave on consecutive beats.
	`PCBE_ASSERT_NEXT(a_burst, child_strobe && !last_child, child_strobe, "child burst broken")
	// The four children of a split are all sub-partitions.
	`PCBE_ASSERT_NEXT(a_split, child_strobe && child_is_node && !last_child, child_is_node, "split child lost its node mark")
	// The block only holds a node off while a burst is still in progress.
	`PCBE_ASSERT_SAME(a_busy, busy, child_strobe && !last_child, "busy without a burst in progress")
	// Busy rises only after a node was offered.
	`PCBE_ASSERT_SAME(a_rise, $rose(busy), $past(start), "busy rose without a node")

endmodule

bind partition_child_block_expander pcbe_checker u_pcbe_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the partition child block expander.
// Holds its own model of the child expansion and a scoreboard class; depends on pcbe_pkg.
`timescale 1ns / 1ps

module tb_top;
	import pcbe_pkg::*;

	typedef struct {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [SIZE_W-1:0] size;
		logic              is_node;
		logic              last;
	} child_beat_t;

	class child_ledger;
		int unsigned frame_rows;
		int unsigned frame_cols;
		child_beat_t forecast[$];
		child_beat_t pending[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			frame_rows = 0;
			frame_cols = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_frame(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
			if (idx == CFG_FRAME_ROWS)
				frame_rows = 32'(data);
			else
				frame_cols = 32'(data);
		endfunction

		function int unsigned width_4x4(int unsigned b);
			case (b)
				0, 1, 16:          return 1;
				2, 3, 4, 18:       return 2;
				5, 6, 7, 17, 20:   return 4;
				8, 9, 10, 19:      return 8;
				11, 12, 13, 21:    return 16;
				default:           return 32;
			endcase
		endfunction

		function int unsigned part_size(ptype_t p, int unsigned b);
			bit square;
			square = (b % 3 == 0) && (b <= 15);
			case (p)
				P_NONE:                   return square ? b : SIZE_INVALID;
				P_SPLIT:                  return (square && b >= 3) ? b - 3 : SIZE_INVALID;
				P_HORZ, P_HORZ_A, P_HORZ_B: return (square && b >= 3) ? b - 1 : SIZE_INVALID;
				P_VERT, P_VERT_A, P_VERT_B: return (square && b >= 3) ? b - 2 : SIZE_INVALID;
				P_HORZ_4: begin
					if (b == 6) return 17;
					if (b == 9) return 19;
					if (b == 12) return 21;
					return SIZE_INVALID;
				end
				default: begin
					if (b == 6) return 16;
					if (b == 9) return 18;
					if (b == 12) return 20;
					return SIZE_INVALID;
				end
			endcase
		endfunction

		function void push_child(int unsigned r, int unsigned c, int unsigned s, bit node);
			child_beat_t k;
			k.row = POS_W'(r);
			k.col = POS_W'(c);
			k.size = SIZE_W'(s);
			k.is_node = node;
			k.last = 1'b0;
			forecast.insert(forecast.size(), k);
		endfunction

		// Fills forecast with the children of one node, in output order.
		function void predict(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
			logic [SIZE_W-1:0] size, logic [SYM_W-1:0] sym);
			int unsigned r, c, b, rows, cols, half, q, sub, spl;
			bit has_rows, has_cols;
			ptype_t p;
			forecast = {};
			r = 32'(row);
			c = 32'(col);
			b = 32'(size);
			rows = (frame_rows > MI_LIMIT_DEF) ? MI_LIMIT_DEF : frame_rows;
			cols = (frame_cols > MI_LIMIT_DEF) ? MI_LIMIT_DEF : frame_cols;
			if (b > BLOCK_LAST || r >= rows || c >= cols)
				return;
			half = width_4x4(b) / 2;
			q = half / 2;
			has_rows = (r + half) < rows;
			has_cols = (c + half) < cols;
			if (b < SIZE_8X8)
				p = P_NONE;
			else if (has_rows && has_cols)
				p = (sym > P_VERT_4) ? P_VERT_4 : ptype_t'(sym);
			else if (has_cols)
				p = sym[0] ? P_SPLIT : P_HORZ;
			else if (has_rows)
				p = sym[0] ? P_SPLIT : P_VERT;
			else
				p = P_SPLIT;
			sub = part_size(p, b);
			spl = part_size(P_SPLIT, b);
			case (p)
				P_NONE: push_child(r, c, sub, 0);
				P_HORZ: begin
					push_child(r, c, sub, 0);
					if (has_rows)
						push_child(r + half, c, sub, 0);
				end
				P_VERT: begin
					push_child(r, c, sub, 0);
					if (has_cols)
						push_child(r, c + half, sub, 0);
				end
				P_SPLIT: begin
					push_child(r, c, sub, 1);
					push_child(r, c + half, sub, 1);
					push_child(r + half, c, sub, 1);
					push_child(r + half, c + half, sub, 1);
				end
				P_HORZ_A: begin
					push_child(r, c, spl, 0);
					push_child(r, c + half, spl, 0);
					push_child(r + half, c, sub, 0);
				end
				P_HORZ_B: begin
					push_child(r, c, sub, 0);
					push_child(r + half, c, spl, 0);
					push_child(r + half, c + half, spl, 0);
				end
				P_VERT_A: begin
					push_child(r, c, spl, 0);
					push_child(r + half, c, spl, 0);
					push_child(r, c + half, sub, 0);
				end
				P_VERT_B: begin
					push_child(r, c, sub, 0);
					push_child(r, c + half, spl, 0);
					push_child(r + half, c + half, spl, 0);
				end
				P_HORZ_4: begin
					push_child(r, c, sub, 0);
					push_child(r + q, c, sub, 0);
					push_child(r + 2 * q, c, sub, 0);
					if (r + 3 * q < rows)
						push_child(r + 3 * q, c, sub, 0);
				end
				default: begin
					push_child(r, c, sub, 0);
					push_child(r, c + q, sub, 0);
					push_child(r, c + 2 * q, sub, 0);
					if (c + 3 * q < cols)
						push_child(r, c + 3 * q, sub, 0);
				end
			endcase
			if (forecast.size() > 0)
				forecast[forecast.size() - 1].last = 1'b1;
		endfunction

		function void note_node(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
			logic [SIZE_W-1:0] size, logic [SYM_W-1:0] sym);
			predict(row, col, size, sym);
			foreach (forecast[i])
				pending.insert(pending.size(), forecast[i]);
		endfunction

		function void match_child(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
			logic [SIZE_W-1:0] size, logic is_node, logic last);
			child_beat_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected child beat: row %0d col %0d size %0d node %0b last %0b",
						row, col, size, is_node, last);
				return;
			end
			e = pending.pop_front();
			if (e.row !== row || e.col !== col || e.size !== size || e.is_node !== is_node ||
				e.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Child mismatch: expected row %0d col %0d size %0d node %0b last %0b, got row %0d col %0d size %0d node %0b last %0b",
						e.row, e.col, e.size, e.is_node, e.last,
						row, col, size, is_node, last);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [POS_W-1:0]     node_row;
	logic [POS_W-1:0]     node_col;
	logic [SIZE_W-1:0]    node_size;
	logic [SYM_W-1:0]     partition_symbol;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FRAME_W-1:0]   cfg_data;
	logic                 child_strobe;
	logic [POS_W-1:0]     child_row;
	logic [POS_W-1:0]     child_col;
	logic [SIZE_W-1:0]    child_size;
	logic                 child_is_node;
	logic                 last_child;

	child_ledger ledger;
	int unsigned node_beats = 0;
	int unsigned cfg_beats = 0;
	int unsigned frame_settings = 0;

	partition_child_block_expander dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.node_row         (node_row),
		.node_col         (node_col),
		.node_size        (node_size),
		.partition_symbol (partition_symbol),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.child_strobe     (child_strobe),
		.child_row        (child_row),
		.child_col        (child_col),
		.child_size       (child_size),
		.child_is_node    (child_is_node),
		.last_child       (last_child)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				ledger.note_node(node_row, node_col, node_size, partition_symbol);
				node_beats++;
			end
			if (cfg_valid && cfg_ready) begin
				ledger.set_frame(cfg_index, cfg_data);
				cfg_beats++;
			end
			if (child_strobe)
				ledger.match_child(child_row, child_col, child_size, child_is_node, last_child);
		end
	end

	task automatic send_node(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
		input logic [SIZE_W-1:0] size, input logic [SYM_W-1:0] sym, input int unsigned idle_pct);
		int unsigned seen;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		node_row = row;
		node_col = col;
		node_size = size;
		partition_symbol = sym;
		seen = node_beats;
		do
			@(negedge clk);
		while (node_beats == seen);
	endtask

	task automatic write_frame(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] data);
		int unsigned seen;
		start = 1'b0;
		while (ledger.pending.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		seen = cfg_beats;
		do
			@(negedge clk);
		while (cfg_beats == seen);
		cfg_valid = 1'b0;
	endtask

	task automatic set_frame_size(input int unsigned rows, input int unsigned cols);
		write_frame(CFG_FRAME_ROWS, FRAME_W'(rows));
		write_frame(CFG_FRAME_COLS, FRAME_W'(cols));
		frame_settings++;
	endtask

	function automatic int unsigned pick_pos(int unsigned span);
		int unsigned lim, reach;
		lim = (span > MI_LIMIT_DEF) ? MI_LIMIT_DEF : span;
		reach = (lim > 40) ? 40 : lim - 1;
		if ($urandom_range(1) == 1)
			return $urandom_range(lim - 1);
		return lim - 1 - $urandom_range(reach);
	endfunction

	// Mostly nodes inside the frame, biased toward the edges; the rest are
	// out-of-range sizes or row positions anywhere in the 14-bit space.
	task automatic run_random(input int unsigned rows, input int unsigned cols,
		input int unsigned target, input int unsigned idle_pct);
		int unsigned made, pick;
		logic [POS_W-1:0] r, c;
		logic [SIZE_W-1:0] b;
		logic [SYM_W-1:0] s;
		made = 0;
		set_frame_size(rows, cols);
		while (made < target) begin
			pick = $urandom_range(99);
			b = (pick < 45) ? SIZE_W'(3 * $urandom_range(5)) : SIZE_W'($urandom_range(BLOCK_LAST));
			s = ($urandom_range(3) == 0) ? SYM_W'($urandom_range(15)) : SYM_W'($urandom_range(9));
			r = POS_W'(pick_pos(rows));
			c = POS_W'(pick_pos(cols));
			if (pick >= 92)
				b = SIZE_W'($urandom_range(31, 22));
			else if (pick >= 85)
				r = POS_W'($urandom_range(16383));
			ledger.predict(r, c, b, s);
			if (ledger.forecast.size() > 0)
				made++;
			send_node(r, c, b, s, idle_pct);
		end
	endtask

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		node_row = '0;
		node_col = '0;
		node_size = '0;
		partition_symbol = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_ROWS;
		cfg_data = '0;
		ledger = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_frame_size(40, 40);
		for (int s = 0; s < 10; s++)
			send_node(0, 0, 12, SYM_W'(s), 35);
		send_node(4, 4, 6, P_HORZ_4, 35);
		send_node(8, 8, 9, P_VERT_4, 35);
		send_node(8, 8, 9, 13, 35);
		send_node(39, 39, 0, P_SPLIT, 35);
		send_node(0, 0, 1, P_SPLIT, 35);
		send_node(0, 0, 2, P_HORZ, 35);
		send_node(0, 0, 18, P_HORZ, 35);
		send_node(0, 0, 22, P_NONE, 35);
		send_node(0, 0, 31, P_SPLIT, 35);
		send_node(40, 0, 3, P_NONE, 35);
		send_node(36, 0, 9, P_NONE, 35);
		send_node(36, 0, 9, P_HORZ, 35);
		send_node(0, 36, 9, P_NONE, 35);
		send_node(0, 36, 9, P_HORZ, 35);
		send_node(36, 36, 9, P_HORZ_A, 35);
		send_node(28, 0, 12, P_HORZ_4, 35);
		send_node(0, 28, 12, P_VERT_4, 35);

		// Frame past the limit; the split children wrap around the 14-bit position.
		set_frame_size(32767, 32767);
		send_node(16383, 16383, 15, P_NONE, 0);
		set_frame_size(0, 16384);
		send_node(0, 0, 3, P_NONE, 0);

		run_random(48, 80, 52, 35);
		run_random(16384, 16384, 52, 35);
		run_random(32767, 32767, 52, 50);
		run_random(1, 1, 52, 50);
		run_random(23, 9, 52, 0);
		run_random(200, 37, 52, 0);

		start = 1'b0;
		while (ledger.pending.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d nodes over %0d frame settings and checked %0d child beats.",
			node_beats, frame_settings, ledger.checked);
		$display("Mismatches: %0d.", ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
